>>> rtl/lmcs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lmcs_pkg
// Shared types and constants of the LED matrix column scanner.
// ----------------------------------------------------------------------------
package lmcs_pkg;

	localparam int unsigned ROWS        = 16;
	localparam int unsigned STORE_DEPTH = 32;
	localparam int unsigned IDX_W       = 5;
	localparam int unsigned HEIGHT_W    = 8;
	localparam int unsigned CFG_IDX_W   = 1;
	localparam int unsigned CFG_DATA_W  = 1;

	// request modes
	localparam logic [1:0] MODE_TICK   = 2'd0;
	localparam logic [1:0] MODE_BAR    = 2'd1;
	localparam logic [1:0] MODE_BITMAP = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SCAN_ENABLE   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SHOW_SPECTRUM = 1'b1;

	// sequencer phases
	localparam logic [3:0] PH_BLANK_SRC0  = 4'd0;
	localparam logic [3:0] PH_BLANK_SRC1  = 4'd1;
	localparam logic [3:0] PH_BLANK_SINK0 = 4'd2;
	localparam logic [3:0] PH_BLANK_SINK1 = 4'd3;
	localparam logic [3:0] PH_BLANK_SINK2 = 4'd4;
	localparam logic [3:0] PH_BLANK_SINK3 = 4'd5;
	localparam logic [3:0] PH_UP_SINK     = 4'd6;
	localparam logic [3:0] PH_UP_SRC      = 4'd7;
	localparam logic [3:0] PH_UP_SINK_OFF = 4'd8;
	localparam logic [3:0] PH_UP_SRC_OFF  = 4'd9;
	localparam logic [3:0] PH_LO_SINK     = 4'd10;
	localparam logic [3:0] PH_LO_SRC      = 4'd11;
	localparam logic [3:0] PH_LO_SINK_OFF = 4'd12;
	localparam logic [3:0] PH_LO_SRC_OFF  = 4'd13;

	// expander addresses
	localparam logic [7:0] ADDR_SRC0  = 8'h70;
	localparam logic [7:0] ADDR_SRC1  = 8'h74;
	localparam logic [7:0] ADDR_SINK0 = 8'h7E;
	localparam logic [7:0] ADDR_SINK1 = 8'h7A;
	localparam logic [7:0] ADDR_SINK2 = 8'h76;
	localparam logic [7:0] ADDR_SINK3 = 8'h72;

	localparam logic [7:0]  ALL_OFF     = 8'hFF;
	localparam logic [15:0] SRC_PATTERN = 16'hFF7F;
	localparam logic [15:0] FULL_COLUMN = 16'hFFFF;

	// one sequencer step, as decoded from the current phase
	typedef struct packed {
		logic       emit;
		logic       use_data;
		logic       lower_half;
		logic [7:0] addr;
		logic [7:0] fixed_byte;
	} scan_cmd_t;

	// byte formatting control carried with a request into the read stage
	typedef struct packed {
		logic       use_data;
		logic       lower_half;
		logic       spectrum;
		logic       bar_valid;
		logic [7:0] fixed_byte;
	} fmt_ctl_t;

	function automatic logic [7:0] sink_addr(input logic [IDX_W-1:0] col);
		logic [7:0] a;
		unique case (col[4:3])
			2'd0:    a = ADDR_SINK0;
			2'd1:    a = ADDR_SINK1;
			2'd2:    a = ADDR_SINK2;
			default: a = ADDR_SINK3;
		endcase
		return a;
	endfunction

	function automatic logic [7:0] source_sel(input logic [IDX_W-1:0] col);
		logic [15:0] w;
		w = SRC_PATTERN >> col[2:0];
		return w[7:0];
	endfunction

endpackage
`default_nettype wire

>>> rtl/led_matrix_column_scanner.sv
`default_nettype none
// ----------------------------------------------------------------------------
// led_matrix_column_scanner
// Scans an LED matrix through I2C port expanders, one expander write a tick.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries requests: a scan tick, a bar
// height write or a bitmap column write. Bar and bitmap writes land in two
// 32-entry RAMs and give no output. An enabled tick gives one expander write
// (address, byte) on the output channel (out_valid/out_stall).
// Path: an accepted tick is registered into the read stage, then into the
// output register that drives out_valid. One request is taken every cycle
// while in_stall is low; the RAM read issued on acceptance returns in the read
// stage, and the registered output stage follows it.
// When the receiver stalls, the output register holds its write and the read
// stage may still take one more request; only once both are full does
// in_stall rise.
// Reset clears the sequencer to phase 0, the upper column to 0, the lower
// column to 16 modulo COLUMNS, and the bar valid bits, so every bar reads as
// zero height. Bitmap entries must be loaded before they are displayed.
// Configuration (scan_enable, show_spectrum) is written through cfg_we.
// ----------------------------------------------------------------------------
module led_matrix_column_scanner #(
	parameter int unsigned COLUMNS = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// configuration
	input  wire logic                                cfg_we,
	input  wire logic [lmcs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [lmcs_pkg::CFG_DATA_W-1:0]     cfg_data,
	// request channel
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [1:0]                          mode,
	input  wire logic [lmcs_pkg::IDX_W-1:0]          column_index,
	input  wire logic [15:0]                         column_value,
	// expander write channel
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [7:0]                               expander_address,
	output logic [7:0]                               expander_byte
);
	import lmcs_pkg::*;

	logic scan_enable_q;
	logic show_spectrum_q;

	logic in_accept;
	logic tick;
	logic bar_we;
	logic bitmap_we;
	logic rd_en;

	scan_cmd_t        cmd;
	logic [IDX_W-1:0] rd_col;

	// bar store valid bits: cleared at reset, set on first write
	logic [STORE_DEPTH-1:0] bar_valid_q;

	logic [HEIGHT_W-1:0] bar_rdata;
	logic [ROWS-1:0]     bitmap_rdata;

	// read stage
	logic       valid_s1;
	logic [7:0] addr_s1;
	fmt_ctl_t   ctl_s1;
	logic       adv_s1;
	logic [7:0] byte_s1;

	// output stage
	logic       out_valid_q;
	logic [7:0] out_addr_q;
	logic [7:0] out_byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_enable_q   <= 1'b0;
			show_spectrum_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SCAN_ENABLE:   scan_enable_q   <= cfg_data[0];
				CFG_SHOW_SPECTRUM: show_spectrum_q <= cfg_data[0];
				default:           ;
			endcase
		end
	end

	assign adv_s1    = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !adv_s1;
	assign in_accept = in_valid && !in_stall;
	assign tick      = in_accept && (mode == MODE_TICK) && scan_enable_q;
	assign bar_we    = in_accept && (mode == MODE_BAR);
	assign bitmap_we = in_accept && (mode == MODE_BITMAP);
	// read only for the steps that show column data, so the read data holds
	assign rd_en     = tick && cmd.use_data;

	lmcs_seq #(
		.COLUMNS (COLUMNS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick),
		.cmd    (cmd),
		.rd_col (rd_col)
	);

	lmcs_ram #(
		.WIDTH (HEIGHT_W),
		.DEPTH (STORE_DEPTH)
	) u_bar_ram (
		.clk   (clk),
		.we    (bar_we),
		.waddr (column_index),
		.wdata (column_value[HEIGHT_W-1:0]),
		.re    (rd_en),
		.raddr (rd_col),
		.rdata (bar_rdata)
	);

	lmcs_ram #(
		.WIDTH (ROWS),
		.DEPTH (STORE_DEPTH)
	) u_bitmap_ram (
		.clk   (clk),
		.we    (bitmap_we),
		.waddr (column_index),
		.wdata (column_value),
		.re    (rd_en),
		.raddr (rd_col),
		.rdata (bitmap_rdata)
	);

	// Writes commit at acceptance and reads issue at acceptance, one request
	// a cycle, so a read always sees every earlier write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bar_valid_q <= '0;
		end else if (bar_we) begin
			bar_valid_q[column_index] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= tick && cmd.emit;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			addr_s1           <= cmd.addr;
			ctl_s1.use_data   <= cmd.use_data;
			ctl_s1.lower_half <= cmd.lower_half;
			ctl_s1.spectrum   <= show_spectrum_q;
			ctl_s1.bar_valid  <= bar_valid_q[rd_col];
			ctl_s1.fixed_byte <= cmd.fixed_byte;
		end
	end

	lmcs_fmt u_fmt (
		.ctl         (ctl_s1),
		.bar_height  (bar_rdata),
		.bitmap_word (bitmap_rdata),
		.byte_out    (byte_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_addr_q <= addr_s1;
			out_byte_q <= byte_s1;
		end
	end

	assign out_valid        = out_valid_q;
	assign expander_address = out_addr_q;
	assign expander_byte    = out_byte_q;

endmodule
`default_nettype wire

>>> rtl/lmcs_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lmcs_ram
// Generic single write port RAM with registered, enabled read.
// ----------------------------------------------------------------------------
module lmcs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/lmcs_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lmcs_seq
// Phase sequencer: decodes the current step and advances phase and columns.
// ----------------------------------------------------------------------------
module lmcs_seq #(
	parameter int unsigned COLUMNS = 32
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      tick,
	output lmcs_pkg::scan_cmd_t            cmd,
	output logic [lmcs_pkg::IDX_W-1:0]     rd_col
);
	import lmcs_pkg::*;

	localparam int unsigned COL_W = $clog2(COLUMNS);
	localparam logic [COL_W-1:0] LOWER_RESET = COL_W'(16 % COLUMNS);
	localparam logic [COL_W-1:0] LAST_COL    = COL_W'(COLUMNS - 1);

	logic [3:0]       phase_q;
	logic [COL_W-1:0] upper_q;
	logic [COL_W-1:0] lower_q;
	logic [IDX_W-1:0] upper_x;
	logic [IDX_W-1:0] lower_x;

	assign upper_x = IDX_W'(upper_q);
	assign lower_x = IDX_W'(lower_q);
	// lower half only reads in its own sink phase
	assign rd_col  = (phase_q == PH_LO_SINK) ? lower_x : upper_x;

	always_comb begin
		cmd = '{emit: 1'b1, use_data: 1'b0, lower_half: 1'b0,
			addr: ADDR_SRC0, fixed_byte: ALL_OFF};
		unique case (phase_q)
			PH_BLANK_SRC0:  cmd.addr = ADDR_SRC0;
			PH_BLANK_SRC1:  cmd.addr = ADDR_SRC1;
			PH_BLANK_SINK0: cmd.addr = ADDR_SINK0;
			PH_BLANK_SINK1: cmd.addr = ADDR_SINK1;
			PH_BLANK_SINK2: cmd.addr = ADDR_SINK2;
			PH_BLANK_SINK3: cmd.addr = ADDR_SINK3;
			PH_UP_SINK: begin
				cmd.addr     = sink_addr(upper_x);
				cmd.use_data = 1'b1;
			end
			PH_UP_SRC: begin
				cmd.addr       = ADDR_SRC1;
				cmd.fixed_byte = source_sel(upper_x);
			end
			PH_UP_SINK_OFF: cmd.addr = sink_addr(upper_x);
			PH_UP_SRC_OFF:  cmd.addr = ADDR_SRC1;
			PH_LO_SINK: begin
				cmd.addr       = sink_addr(lower_x);
				cmd.use_data   = 1'b1;
				cmd.lower_half = 1'b1;
			end
			PH_LO_SRC: begin
				cmd.addr       = ADDR_SRC0;
				cmd.fixed_byte = source_sel(lower_x);
			end
			PH_LO_SINK_OFF: cmd.addr = sink_addr(lower_x);
			PH_LO_SRC_OFF:  cmd.addr = ADDR_SRC0;
			default:        cmd.emit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BLANK_SRC0;
			upper_q <= '0;
			lower_q <= LOWER_RESET;
		end else if (tick) begin
			priority case (1'b1)
				!cmd.emit: phase_q <= PH_BLANK_SRC0;
				phase_q == PH_LO_SRC_OFF: begin
					phase_q <= PH_UP_SINK;
					lower_q <= (lower_q == LAST_COL) ? '0 : lower_q + 1'b1;
				end
				default: begin
					phase_q <= phase_q + 4'd1;
					if (phase_q == PH_UP_SRC_OFF) begin
						upper_q <= (upper_q == LAST_COL) ? '0 : upper_q + 1'b1;
					end
				end
			endcase
		end
	end

endmodule
`default_nettype wire

>>> rtl/lmcs_fmt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lmcs_fmt
// Column byte formatter: thermometer bar or bitmap half, or a fixed byte.
// ----------------------------------------------------------------------------
module lmcs_fmt (
	input  wire lmcs_pkg::fmt_ctl_t              ctl,
	input  wire logic [lmcs_pkg::HEIGHT_W-1:0]   bar_height,
	input  wire logic [lmcs_pkg::ROWS-1:0]       bitmap_word,
	output logic      [7:0]                      byte_out
);
	import lmcs_pkg::*;

	logic [HEIGHT_W-1:0] h;
	logic [ROWS-1:0]     word;

	// an unwritten bar reads as height zero
	assign h = ctl.bar_valid ? bar_height : '0;

	always_comb begin
		if (!ctl.spectrum) begin
			word = bitmap_word;
		end else if (h[HEIGHT_W-1:4] != '0) begin
			word = '0;
		end else begin
			word = FULL_COLUMN >> h[3:0];
		end
		if (!ctl.use_data) begin
			byte_out = ctl.fixed_byte;
		end else if (ctl.lower_half) begin
			byte_out = word[15:8];
		end else begin
			byte_out = word[7:0];
		end
	end

endmodule
`default_nettype wire
